/* hdl/kehid_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kehid_pkg
// Shared types, constants and the key code to usage table of the key event
// to boot keyboard report block.
// ----------------------------------------------------------------------------
package kehid_pkg;

  localparam int CodeW       = 7;
  localparam int UsageW      = 8;
  localparam int ReportSlots = 6;

  typedef logic [CodeW-1:0]  code_t;
  typedef logic [UsageW-1:0] usage_t;

  localparam usage_t NoUsage  = 8'h00;
  localparam usage_t ModFirst = 8'hE0;
  localparam usage_t ModLast  = 8'hE7;

  // Command from the event stage to the key slot store
  typedef struct packed {
    logic   en;     // apply this event to the slots
    logic   down;   // press when set, release when clear
    usage_t usage;  // nonzero, non-modifier usage
  } slot_cmd_t;

  // Key code to keyboard usage; 0 marks a code with no usage
  localparam usage_t UsageTable [128] = '{
    8'h04, 8'h16, 8'h07, 8'h09, 8'h0b, 8'h0a, 8'h1d, 8'h1b,
    8'h06, 8'h19, 8'h00, 8'h05, 8'h14, 8'h1a, 8'h08, 8'h15,
    8'h1c, 8'h17, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h23, 8'h22,
    8'h2e, 8'h26, 8'h24, 8'h2d, 8'h25, 8'h27, 8'h30, 8'h12,
    8'h18, 8'h2f, 8'h0c, 8'h13, 8'h28, 8'h0f, 8'h0d, 8'h34,
    8'h0e, 8'h33, 8'h31, 8'h36, 8'h38, 8'h11, 8'h10, 8'h37,
    8'h2b, 8'h2c, 8'h35, 8'h2a, 8'h00, 8'h29, 8'he0, 8'he3,
    8'he1, 8'h39, 8'he2, 8'h50, 8'h4f, 8'h51, 8'h52, 8'h00,
    8'h00, 8'h63, 8'h00, 8'h55, 8'h00, 8'h57, 8'h00, 8'h00,
    8'h00, 8'h54, 8'h58, 8'h00, 8'h56, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h62, 8'h59, 8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e,
    8'h5f, 8'h60, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h3e, 8'h3f, 8'h40, 8'h3c, 8'h41, 8'h42, 8'h00, 8'h44,
    8'h00, 8'h00, 8'h00, 8'h43, 8'h00, 8'h45, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h4a, 8'h4b, 8'h4c, 8'h3d, 8'h4d, 8'h3b,
    8'h4e, 8'h3a, 8'he5, 8'he6, 8'he4, 8'h00, 8'h00, 8'h00
  };

endpackage
`default_nettype wire

/* hdl/key_event_to_hid_boot_report.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// key_event_to_hid_boot_report
// Turns key press/release events into the eight-byte boot keyboard report
// (modifier byte and six key slots; the reserved byte is always zero).
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake               | Payload
//  ----------+-------------------------+-----------------------------------
//  event in  | start_i / busy_o        | key_code_i, key_down_i
//  report out| done_o (one-cycle pulse)| mapped_o, modifier_bits_o,
//            |                         | slot_zero_o .. slot_five_o
//
//  An event transfers on a clock edge with start_i high and busy_o low.
//  busy_o never rises: one event is taken every cycle, back to back.
//  The transfer edge loads the event register, which in turn loads the report
//  register; the report is shown from the report register and must be taken
//  while shown. done_o is high for that cycle only.
//  The receiver cannot stall; each report must be taken when shown.
//  Reset (rst_ni low, asynchronous) clears the modifier byte, empties every
//  key slot and drops any event in flight.
//
module key_event_to_hid_boot_report #(
  parameter int KeySlots = 6
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // event in
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire kehid_pkg::code_t key_code_i,
  input  wire                   key_down_i,
  // report out
  output logic                  done_o,
  output logic                  mapped_o,
  output kehid_pkg::usage_t     modifier_bits_o,
  output kehid_pkg::usage_t     slot_zero_o,
  output kehid_pkg::usage_t     slot_one_o,
  output kehid_pkg::usage_t     slot_two_o,
  output kehid_pkg::usage_t     slot_three_o,
  output kehid_pkg::usage_t     slot_four_o,
  output kehid_pkg::usage_t     slot_five_o
);
  import kehid_pkg::*;

  // ---- event register -------------------------------------------------------
  logic  ev_valid_q;
  code_t ev_code_q;
  logic  ev_down_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else begin
      ev_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ev_code_q <= key_code_i;
      ev_down_q <= key_down_i;
    end
  end

  // ---- decode ---------------------------------------------------------------
  usage_t usage;
  logic   is_mapped;
  logic   is_mod;

  assign usage     = UsageTable[ev_code_q];
  assign is_mapped = (usage != NoUsage);
  assign is_mod    = usage inside {[ModFirst:ModLast]};

  // ---- modifier byte --------------------------------------------------------
  usage_t mod_q, mod_d;
  usage_t mod_bit;

  assign mod_bit = usage_t'(1) << usage[2:0];

  always_comb begin
    mod_d = mod_q;
    if (ev_valid_q && is_mapped && is_mod) begin
      if (ev_down_q) begin
        mod_d = mod_q | mod_bit;
      end else begin
        mod_d = mod_q & ~mod_bit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= '0;
    end else begin
      mod_q <= mod_d;
    end
  end

  // ---- key slots ------------------------------------------------------------
  slot_cmd_t             slot_cmd;
  usage_t [KeySlots-1:0] slots_next;

  assign slot_cmd.en    = ev_valid_q && is_mapped && !is_mod;
  assign slot_cmd.down  = ev_down_q;
  assign slot_cmd.usage = usage;

  kehid_slots #(
    .KeySlots (KeySlots)
  ) u_slots (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (slot_cmd),
    .slots_next_o (slots_next)
  );

  // Only the first six slots are reported; missing slots read empty
  usage_t [ReportSlots-1:0] report;

  for (genvar j = 0; j < ReportSlots; j++) begin : g_report
    if (j < KeySlots) begin : g_held
      assign report[j] = slots_next[j];
    end else begin : g_none
      assign report[j] = NoUsage;
    end
  end

  // ---- report register ------------------------------------------------------
  logic                     done_q;
  logic                     mapped_q;
  usage_t                   rep_mod_q;
  usage_t [ReportSlots-1:0] rep_slots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ev_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_valid_q) begin
      mapped_q    <= is_mapped;
      rep_mod_q   <= mod_d;
      rep_slots_q <= report;
    end
  end

  assign done_o          = done_q;
  assign mapped_o        = mapped_q;
  assign modifier_bits_o = rep_mod_q;
  assign slot_zero_o     = rep_slots_q[0];
  assign slot_one_o      = rep_slots_q[1];
  assign slot_two_o      = rep_slots_q[2];
  assign slot_three_o    = rep_slots_q[3];
  assign slot_four_o     = rep_slots_q[4];
  assign slot_five_o     = rep_slots_q[5];

endmodule
`default_nettype wire

/* hdl/kehid_slots.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kehid_slots
// Key slot store: parallel usage match, first-free pick on press, clear of
// the matching slot on release. Presents the next slot contents.
// ----------------------------------------------------------------------------
module kehid_slots #(
  parameter int KeySlots = 6
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire kehid_pkg::slot_cmd_t           cmd_i,
  output kehid_pkg::usage_t [KeySlots-1:0]    slots_next_o
);
  import kehid_pkg::*;

  usage_t [KeySlots-1:0] slots_q, slots_d;
  logic   [KeySlots-1:0] hit, empty;
  logic                  any_hit;
  logic                  taken;

  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      hit[i]   = (slots_q[i] == cmd_i.usage);
      empty[i] = (slots_q[i] == NoUsage);
    end
  end

  assign any_hit = |hit;

  // Press of a new key fills the lowest empty slot; release clears its slot.
  // A press with every slot taken falls through unchanged.
  always_comb begin
    slots_d = slots_q;
    taken   = 1'b0;
    if (cmd_i.en) begin
      for (int i = 0; i < KeySlots; i++) begin
        if (!taken) begin
          if (cmd_i.down && !any_hit && empty[i]) begin
            slots_d[i] = cmd_i.usage;
            taken      = 1'b1;
          end else if (!cmd_i.down && hit[i]) begin
            slots_d[i] = NoUsage;
            taken      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
    end else begin
      slots_q <= slots_d;
    end
  end

  assign slots_next_o = slots_d;

endmodule
`default_nettype wire

/* dv/tb_key_event_to_hid_boot_report.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_event_to_hid_boot_report
// Drives key press and release events into the boot report block. Every
// report is checked against a local model of the modifier byte and the key
// slots. The run starts with a short table of directed events and then
// sends random bursts that mostly work over a narrow window of key codes, so
// that presses repeat, slots fill up and releases find their keys.
// ----------------------------------------------------------------------------
module tb_key_event_to_hid_boot_report;
  import kehid_pkg::*;

  localparam int KEY_SLOTS    = 6;
  localparam int RANDOM_EVENTS = 1550;
  localparam int DRAIN_CYCLES = 8;   // margin after the last report
  localparam int DIR_ROWS     = 25;

  // One boot report as the block shows it (reserved byte not carried)
  typedef struct packed {
    logic              mapped;
    usage_t            mods;
    logic [5:0][7:0]   slots;   // slots[i] is key slot i
  } boot_report_t;

  // Directed row. With lit set the report is typed in here: mapped, the
  // modifier byte and slot 0, every other slot zero.
  typedef struct packed {
    code_t  code;
    logic   down;
    logic   lit;
    logic   mapped;
    usage_t mods;
    usage_t slot0;
  } stim_row_t;

  // Key code to usage, kept apart from the design's own copy
  localparam usage_t KeyUsage [128] = '{
    8'h04, 8'h16, 8'h07, 8'h09, 8'h0b, 8'h0a, 8'h1d, 8'h1b,
    8'h06, 8'h19, 8'h00, 8'h05, 8'h14, 8'h1a, 8'h08, 8'h15,
    8'h1c, 8'h17, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h23, 8'h22,
    8'h2e, 8'h26, 8'h24, 8'h2d, 8'h25, 8'h27, 8'h30, 8'h12,
    8'h18, 8'h2f, 8'h0c, 8'h13, 8'h28, 8'h0f, 8'h0d, 8'h34,
    8'h0e, 8'h33, 8'h31, 8'h36, 8'h38, 8'h11, 8'h10, 8'h37,
    8'h2b, 8'h2c, 8'h35, 8'h2a, 8'h00, 8'h29, 8'he0, 8'he3,
    8'he1, 8'h39, 8'he2, 8'h50, 8'h4f, 8'h51, 8'h52, 8'h00,
    8'h00, 8'h63, 8'h00, 8'h55, 8'h00, 8'h57, 8'h00, 8'h00,
    8'h00, 8'h54, 8'h58, 8'h00, 8'h56, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h62, 8'h59, 8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e,
    8'h5f, 8'h60, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h3e, 8'h3f, 8'h40, 8'h3c, 8'h41, 8'h42, 8'h00, 8'h44,
    8'h00, 8'h00, 8'h00, 8'h43, 8'h00, 8'h45, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h4a, 8'h4b, 8'h4c, 8'h3d, 8'h4d, 8'h3b,
    8'h4e, 8'h3a, 8'he5, 8'he6, 8'he4, 8'h00, 8'h00, 8'h00
  };

  //          code    down  lit   map   mods   slot0
  localparam stim_row_t DirectedEvents [DIR_ROWS] = '{
    '{7'd10,  1'b1, 1'b1, 1'b0, 8'h00, 8'h00},  // no usage, right after reset
    '{7'd127, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00},  // top code, no usage
    '{7'd0,   1'b1, 1'b1, 1'b1, 8'h00, 8'h04},  // lowest code into slot 0
    '{7'd0,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},  // press already held
    '{7'd1,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd2,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd3,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd4,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd5,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},  // all six slots now held
    '{7'd6,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},  // dropped, no slot free
    '{7'd2,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00},  // frees slot 2
    '{7'd6,   1'b1, 1'b0, 1'b0, 8'h00, 8'h00},  // lands in slot 2
    '{7'd7,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00},  // release of a key not held
    '{7'd54,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00},  // modifiers E0..E6
    '{7'd56,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd58,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd55,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd124, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd122, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd123, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},
    '{7'd54,  1'b0, 1'b0, 1'b0, 8'h00, 8'h00},  // modifier release
    '{7'd126, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00},  // no usage, state kept
    '{7'd0,   1'b0, 1'b0, 1'b0, 8'h00, 8'h00},  // release from slot 0
    '{7'd52,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00},  // no usage mid table
    '{7'd65,  1'b1, 1'b0, 1'b0, 8'h00, 8'h00}   // refills slot 0
  };

  logic   clk_i      = 1'b0;
  logic   rst_ni     = 1'b0;
  logic   start_i    = 1'b0;
  code_t  key_code_i = '0;
  logic   key_down_i = 1'b0;

  logic   busy_o;
  logic   done_o;
  logic   mapped_o;
  usage_t modifier_bits_o;
  usage_t slot_zero_o, slot_one_o, slot_two_o;
  usage_t slot_three_o, slot_four_o, slot_five_o;

  // Local copy of the keyboard state
  usage_t       held_mods;
  usage_t       held_usage [KEY_SLOTS];

  boot_report_t pending_reports [$];
  int unsigned  mismatch_count = 0;
  int unsigned  reports_seen   = 0;

  key_event_to_hid_boot_report #(
    .KeySlots(KEY_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .key_code_i     (key_code_i),
    .key_down_i     (key_down_i),
    .done_o         (done_o),
    .mapped_o       (mapped_o),
    .modifier_bits_o(modifier_bits_o),
    .slot_zero_o    (slot_zero_o),
    .slot_one_o     (slot_one_o),
    .slot_two_o     (slot_two_o),
    .slot_three_o   (slot_three_o),
    .slot_four_o    (slot_four_o),
    .slot_five_o    (slot_five_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one event to the local state and return the report it leaves.
  // Modifier usages set or clear a bit; other usages are matched against the
  // slots, a new press taking the lowest empty one.
  function automatic boot_report_t apply_key_event(code_t code, logic down);
    boot_report_t rpt;
    usage_t       usage;
    usage_t       mod_bit;
    int           hit;
    int           free_slot;
    usage = KeyUsage[code];
    rpt.mapped = (usage != NoUsage);
    if (usage != NoUsage) begin
      if (usage >= ModFirst && usage <= ModLast) begin
        mod_bit = usage_t'(8'h01 << (usage - ModFirst));
        if (down) held_mods = held_mods | mod_bit;
        else      held_mods = held_mods & ~mod_bit;
      end else begin
        hit = -1;
        for (int i = 0; i < KEY_SLOTS; i++)
          if (hit < 0 && held_usage[i] == usage) hit = i;
        if (down) begin
          if (hit < 0) begin
            free_slot = -1;
            for (int i = 0; i < KEY_SLOTS; i++)
              if (free_slot < 0 && held_usage[i] == NoUsage) free_slot = i;
            // all slots full: press is dropped
            if (free_slot >= 0) held_usage[free_slot] = usage;
          end
        end else if (hit >= 0) begin
          held_usage[hit] = NoUsage;
        end
      end
    end
    rpt.mods = held_mods;
    for (int j = 0; j < 6; j++)
      rpt.slots[j] = (j < KEY_SLOTS) ? held_usage[j] : NoUsage;
    return rpt;
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH report %0d: %s", reports_seen, msg);
    mismatch_count++;
  endtask

  // Drive one event and hold it until it transfers, then queue its report
  task automatic send_key_event(code_t code, logic down);
    start_i    <= 1'b1;
    key_code_i <= code;
    key_down_i <= down;
    do @(posedge clk_i); while (busy_o);
    pending_reports.push_back(apply_key_event(code, down));
  endtask

  // Stop sending until every queued report has come back
  task automatic wait_reports_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Report checker: done_o marks a report for one cycle only, so it is
  // sampled at every edge and compared with the oldest queued report.
  always @(posedge clk_i) begin : check_reports
    boot_report_t got;
    boot_report_t want;
    if (rst_ni && done_o) begin
      got.mapped   = mapped_o;
      got.mods     = modifier_bits_o;
      got.slots[0] = slot_zero_o;
      got.slots[1] = slot_one_o;
      got.slots[2] = slot_two_o;
      got.slots[3] = slot_three_o;
      got.slots[4] = slot_four_o;
      got.slots[5] = slot_five_o;
      if (pending_reports.size() == 0) begin
        note_mismatch("report with no event waiting");
      end else begin
        want = pending_reports.pop_front();
        if (got.mapped !== want.mapped)
          note_mismatch($sformatf("mapped got %0b want %0b", got.mapped, want.mapped));
        if (got.mods !== want.mods)
          note_mismatch($sformatf("modifier_bits got %02h want %02h", got.mods, want.mods));
        for (int i = 0; i < 6; i++)
          if (got.slots[i] !== want.slots[i])
            note_mismatch($sformatf("slot %0d got %02h want %02h",
                                    i, got.slots[i], want.slots[i]));
      end
      reports_seen++;
    end
  end

  initial begin : stimulus
    boot_report_t lit_rpt;
    stim_row_t    row;
    int unsigned  burst_left;
    int unsigned  gap;
    int unsigned  press_pct;
    int unsigned  pick;
    code_t        window_base;
    code_t        rnd_code;
    logic         rnd_down;

    held_mods = NoUsage;
    for (int i = 0; i < KEY_SLOTS; i++) held_usage[i] = NoUsage;
    burst_left  = 0;
    press_pct   = 50;
    window_base = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back. Literal rows override the model's report.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DirectedEvents[r];
      send_key_event(row.code, row.down);
      if (row.lit) begin
        lit_rpt          = '0;
        lit_rpt.mapped   = row.mapped;
        lit_rpt.mods     = row.mods;
        lit_rpt.slots[0] = row.slot0;
        pending_reports[pending_reports.size()-1] = lit_rpt;
      end
    end
    wait_reports_drained();

    // Random bursts. Each block of 100 events works mostly over a window of
    // twelve codes with its own press bias, so keys get pressed twice,
    // slots fill and releases hit held keys; the rest is any code at all.
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 100 == 0) begin
        window_base = code_t'($urandom_range(0, 127));
        press_pct   = $urandom_range(30, 85);
      end
      if (n == RANDOM_EVENTS / 2) begin
        wait_reports_drained();
        burst_left = $urandom_range(1, 40);
      end else if (burst_left == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      gap = $urandom_range(1, 4);
        else if (pick < 9) gap = $urandom_range(5, 12);
        else               gap = $urandom_range(20, 40);
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 40);
      end
      if ($urandom_range(0, 9) < 7)
        rnd_code = code_t'(window_base + $urandom_range(0, 11));
      else
        rnd_code = code_t'($urandom_range(0, 127));
      rnd_down = ($urandom_range(1, 100) <= press_pct);
      send_key_event(rnd_code, rnd_down);
      burst_left--;
    end

    start_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("key_event_to_hid_boot_report verification clean");
    end else begin
      $display("key_event_to_hid_boot_report verification failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under 20k cycles
  initial begin : watchdog
    #400_000;
    $display("key_event_to_hid_boot_report verification failed");
    $finish;
  end

endmodule

/* key_event_to_hid_boot_report.f */
hdl/kehid_pkg.sv
hdl/kehid_slots.sv
hdl/key_event_to_hid_boot_report.sv
dv/tb_key_event_to_hid_boot_report.sv
